>>> rtl/core/spq_pkg.sv
// Shared constants, codes, types and helpers for the stable priority queue
package spq_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int TAG_BITS_DEF = 16;

   localparam int CMD_W    = 1;
   localparam int LEVEL_W  = 3;
   localparam int TAG_W    = 16;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;

   localparam logic [LEVEL_W-1:0] LEVEL_MIN = 3'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 3'd5;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_POP    = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   localparam logic [1:0] OP_IDLE   = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_POP    = 2'd2;
   localparam logic [1:0] OP_REJECT = 2'd3;

   typedef struct packed {
      logic                load;
      logic [1:0]          op;
      logic [STATUS_W-1:0] status;
   } spq_ctl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } spq_sts_type;

   function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] lv);
      logic [LEVEL_W-1:0] res;
      if (lv < LEVEL_MIN) begin
         res = LEVEL_MIN;
      end else if (lv > LEVEL_MAX) begin
         res = LEVEL_MAX;
      end else begin
         res = lv;
      end
      return res;
   endfunction

endpackage

>>> rtl/core/spq_req_if.sv
// Request channel: operation, level and tag of one item
interface spq_req_if;
   logic                        valid;
   logic                        ready;
   logic [spq_pkg::CMD_W-1:0]   cmd;
   logic [spq_pkg::LEVEL_W-1:0] prio_level;
   logic [spq_pkg::TAG_W-1:0]   order_tag;

   modport source (output valid, output cmd, output prio_level, output order_tag,
                   input ready);
   modport sink   (input valid, input cmd, input prio_level, input order_tag,
                   output ready);
endinterface

>>> rtl/core/spq_rsp_if.sv
// Response channel: status, popped entry and occupancy of one item
interface spq_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [spq_pkg::STATUS_W-1:0] status;
   logic                         out_valid;
   logic [spq_pkg::LEVEL_W-1:0]  out_level;
   logic [spq_pkg::TAG_W-1:0]    out_tag;
   logic [spq_pkg::OCC_W-1:0]    occupancy;

   modport source (output valid, output status, output out_valid, output out_level,
                   output out_tag, output occupancy, input ready);
   modport sink   (input valid, input status, input out_valid, input out_level,
                   input out_tag, input occupancy, output ready);
endinterface

>>> rtl/core/spq_ctrl.sv
// Controller: handshake, response hold and operation select
module spq_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic [spq_pkg::CMD_W-1:0] req_cmd,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  spq_pkg::spq_sts_type      sts,
   output spq_pkg::spq_ctl_type      ctl
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_HOLD = 1'b1;

   logic state_ff;
   logic state_in;
   logic accept;

   assign req_ready = (state_ff == ST_IDLE) || rsp_ready;
   assign rsp_valid = (state_ff == ST_HOLD);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (accept) begin
               state_in = ST_HOLD;
            end else if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctl.load   = accept;
      ctl.op     = spq_pkg::OP_IDLE;
      ctl.status = spq_pkg::STATUS_OK;
      if (accept) begin
         if (req_cmd == spq_pkg::CMD_POP) begin
            if (sts.empty) begin
               ctl.op     = spq_pkg::OP_REJECT;
               ctl.status = spq_pkg::STATUS_EMPTY;
            end else begin
               ctl.op = spq_pkg::OP_POP;
            end
         end else begin
            if (sts.full) begin
               ctl.op     = spq_pkg::OP_REJECT;
               ctl.status = spq_pkg::STATUS_FULL;
            end else begin
               ctl.op = spq_pkg::OP_INSERT;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/core/spq_datapath.sv
// Datapath: sorted row of entry cells, entry count and response register
module spq_datapath #(
   parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
   parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  spq_pkg::spq_ctl_type         ctl,
   output spq_pkg::spq_sts_type         sts,
   input  logic [spq_pkg::LEVEL_W-1:0]  req_level,
   input  logic [spq_pkg::TAG_W-1:0]    req_tag,
   output logic [spq_pkg::STATUS_W-1:0] status,
   output logic                         out_valid,
   output logic [spq_pkg::LEVEL_W-1:0]  out_level,
   output logic [spq_pkg::TAG_W-1:0]    out_tag,
   output logic [spq_pkg::OCC_W-1:0]    occupancy
);

   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int STORE_W = (TAG_BITS < spq_pkg::TAG_W) ? TAG_BITS : spq_pkg::TAG_W;

   logic [spq_pkg::LEVEL_W-1:0] level_ff [CAPACITY];
   logic [spq_pkg::LEVEL_W-1:0] level_in [CAPACITY];
   logic [STORE_W-1:0]          tag_ff   [CAPACITY];
   logic [STORE_W-1:0]          tag_in   [CAPACITY];
   logic [CAPACITY-1:0]         ge;
   logic [CNT_W-1:0]            count_ff;
   logic [CNT_W-1:0]            count_in;
   logic [spq_pkg::LEVEL_W-1:0] new_level;
   logic [STORE_W-1:0]          new_tag;

   logic [spq_pkg::STATUS_W-1:0] status_ff;
   logic                         out_valid_ff;
   logic [spq_pkg::LEVEL_W-1:0]  out_level_ff;
   logic [spq_pkg::TAG_W-1:0]    out_tag_ff;
   logic [spq_pkg::OCC_W-1:0]    occupancy_ff;

   assign new_level = spq_pkg::clamp_level(req_level);
   assign new_tag   = req_tag[STORE_W-1:0];

   assign sts.full  = (count_ff == CNT_W'(CAPACITY));
   assign sts.empty = (count_ff == '0);

   // held entries at or above the new level stay ahead of it
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         ge[i] = (CNT_W'(i) < count_ff) && (level_ff[i] >= new_level);
      end
   end

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         level_in[i] = level_ff[i];
         tag_in[i]   = tag_ff[i];
         if (ctl.op == spq_pkg::OP_INSERT) begin
            if (!ge[i]) begin
               if (i == 0) begin
                  level_in[i] = new_level;
                  tag_in[i]   = new_tag;
               end else if (ge[(i == 0) ? 0 : i - 1]) begin
                  level_in[i] = new_level;
                  tag_in[i]   = new_tag;
               end else begin
                  level_in[i] = level_ff[(i == 0) ? 0 : i - 1];
                  tag_in[i]   = tag_ff[(i == 0) ? 0 : i - 1];
               end
            end
         end else if (ctl.op == spq_pkg::OP_POP) begin
            if (i < CAPACITY - 1) begin
               level_in[i] = level_ff[(i < CAPACITY - 1) ? i + 1 : i];
               tag_in[i]   = tag_ff[(i < CAPACITY - 1) ? i + 1 : i];
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      case (ctl.op)
         spq_pkg::OP_INSERT: count_in = count_ff + CNT_W'(1);
         spq_pkg::OP_POP:    count_in = count_ff - CNT_W'(1);
         default:            count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         level_ff[i] <= level_in[i];
         tag_ff[i]   <= tag_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         status_ff    <= ctl.status;
         occupancy_ff <= spq_pkg::OCC_W'(count_in);
         if (ctl.op == spq_pkg::OP_POP) begin
            out_valid_ff <= 1'b1;
            out_level_ff <= level_ff[0];
            out_tag_ff   <= spq_pkg::TAG_W'(tag_ff[0]);
         end else begin
            out_valid_ff <= 1'b0;
            out_level_ff <= '0;
            out_tag_ff   <= '0;
         end
      end
   end

   assign status    = status_ff;
   assign out_valid = out_valid_ff;
   assign out_level = out_level_ff;
   assign out_tag   = out_tag_ff;
   assign occupancy = occupancy_ff;

endmodule

>>> rtl/core/stable_priority_queue.sv
// Top level of the stable priority queue
//
//   channel   role    payload                                      size
//   req_ch    sink    cmd, prio_level, order_tag                   1 + 3 + 16
//   rsp_ch    source  status, out_valid, out_level, out_tag,       2 + 1 + 3 + 16 + 5
//                     occupancy
//
// One item per clock: an insert or pop settles in the cycle it is taken, by a
// compare-and-shift across the row of entry cells, and its response is in the
// output register on the next cycle. A new item is taken while the response
// waits only in a cycle where that response is also taken. Reset clears the
// entry count and the response valid; no clearing pass is needed.
module stable_priority_queue #(
   parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
   parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   spq_req_if.sink    req_ch,
   spq_rsp_if.source  rsp_ch
);

   spq_pkg::spq_ctl_type ctl;
   spq_pkg::spq_sts_type sts;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_cmd   (req_ch.cmd),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   spq_datapath #(
      .CAPACITY (CAPACITY),
      .TAG_BITS (TAG_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .sts       (sts),
      .req_level (req_ch.prio_level),
      .req_tag   (req_ch.order_tag),
      .status    (rsp_ch.status),
      .out_valid (rsp_ch.out_valid),
      .out_level (rsp_ch.out_level),
      .out_tag   (rsp_ch.out_tag),
      .occupancy (rsp_ch.occupancy)
   );

endmodule

>>> rtl/core/spq_checker.sv
// Port checker for the stable priority queue, bound to the top level
module spq_checker #(
   parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [spq_pkg::STATUS_W-1:0] status,
   input logic                         out_valid,
   input logic [spq_pkg::LEVEL_W-1:0]  out_level,
   input logic [spq_pkg::TAG_W-1:0]    out_tag,
   input logic [spq_pkg::OCC_W-1:0]    occupancy
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(status) && $stable(out_tag) && $stable(occupancy))
      else $error("stalled response changed");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == spq_pkg::STATUS_EMPTY |->
         occupancy == '0 && !out_valid && out_level == '0)
      else $error("empty report with entries or popped data");

   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == spq_pkg::STATUS_FULL |->
         occupancy == spq_pkg::OCC_W'(CAPACITY) && !out_valid)
      else $error("full report below capacity");

endmodule

bind stable_priority_queue spq_checker #(
   .CAPACITY (CAPACITY)
) u_spq_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .status    (rsp_ch.status),
   .out_valid (rsp_ch.out_valid),
   .out_level (rsp_ch.out_level),
   .out_tag   (rsp_ch.out_tag),
   .occupancy (rsp_ch.occupancy)
);
